// ----- rtl/bfss_pkg.sv -----
// Shared constants, codes and control types for the brute-force substring search unit.
package bfss_pkg;

  // Store sizes and the widths that follow from them.
  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 1024;
  localparam int PCNT_W      = $clog2(PATTERN_MAX + 1);
  localparam int PADDR_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int TCNT_W      = $clog2(TEXT_MAX + 1);
  localparam int TADDR_W     = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int SYM_W       = 8;
  localparam int ACT_W       = 2;
  localparam int POS_W       = 10;

  // Item action codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_PATTERN = 2'd0,
    ACT_TEXT    = 2'd1,
    ACT_SEARCH  = 2'd2
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_pat;
    logic load_txt;
    logic init;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;
  } dp_status_t;

endpackage

// ----- rtl/bfss_ctrl.sv -----
// Controller state machine for the brute-force substring search unit.
module bfss_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bfss_pkg::ACT_W-1:0]    in_action,
  input  bfss_pkg::dp_status_t          status,
  output bfss_pkg::ctrl_cmd_t           cmd,
  output logic                          busy,
  output logic                          out_valid
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_CMP   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_action)
            bfss_pkg::ACT_PATTERN: cmd.load_pat = 1'b1;
            bfss_pkg::ACT_TEXT:    cmd.load_txt = 1'b1;
            bfss_pkg::ACT_SEARCH: begin
              cmd.init  = 1'b1;
              state_nxt = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        // The stores are read at the current indices during this cycle.
        if (status.more) begin
          state_nxt = S_CMP;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = S_CHECK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.finish;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// ----- rtl/bfss_datapath.sv -----
// Datapath for the brute-force substring search unit: stores, counts, indices and result.
module bfss_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfss_pkg::ctrl_cmd_t           cmd,
  input  logic [bfss_pkg::SYM_W-1:0]    in_symbol,
  output bfss_pkg::dp_status_t          status,
  output logic                          out_found,
  output logic [bfss_pkg::POS_W-1:0]    out_position,
  output logic                          out_overflow
);

  logic [bfss_pkg::SYM_W-1:0]  pat_mem [bfss_pkg::PATTERN_MAX];
  logic [bfss_pkg::SYM_W-1:0]  txt_mem [bfss_pkg::TEXT_MAX];
  logic [bfss_pkg::SYM_W-1:0]  pat_q_r;
  logic [bfss_pkg::SYM_W-1:0]  txt_q_r;

  logic [bfss_pkg::PCNT_W-1:0] pat_cnt_r, pat_cnt_nxt;
  logic [bfss_pkg::TCNT_W-1:0] txt_cnt_r, txt_cnt_nxt;
  logic                        drop_r, drop_nxt;
  logic [bfss_pkg::TCNT_W-1:0] i_r, i_nxt;
  logic [bfss_pkg::PCNT_W-1:0] j_r, j_nxt;
  logic                        found_r;
  logic [bfss_pkg::POS_W-1:0]  pos_r;
  logic                        ovf_r;

  logic                        pat_room;
  logic                        txt_room;
  logic                        pat_wr;
  logic                        txt_wr;
  logic                        j_short;
  logic [bfss_pkg::TCNT_W-1:0] start_pos;

  assign pat_room = (pat_cnt_r < bfss_pkg::PCNT_W'(bfss_pkg::PATTERN_MAX));
  assign txt_room = (txt_cnt_r < bfss_pkg::TCNT_W'(bfss_pkg::TEXT_MAX));
  assign pat_wr   = cmd.load_pat && pat_room;
  assign txt_wr   = cmd.load_txt && txt_room;

  // The search goes on while both indices are inside their filled ranges.
  assign j_short     = (j_r < pat_cnt_r);
  assign status.more = j_short && (i_r < txt_cnt_r);
  assign start_pos   = i_r - bfss_pkg::TCNT_W'(j_r);

  // Pattern store: one write port, registered read at the pattern index.
  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_mem[pat_cnt_r[bfss_pkg::PADDR_W-1:0]] <= in_symbol;
    end
    pat_q_r <= pat_mem[j_r[bfss_pkg::PADDR_W-1:0]];
  end

  // Text store: one write port, registered read at the text index.
  always_ff @(posedge clk) begin
    if (txt_wr) begin
      txt_mem[txt_cnt_r[bfss_pkg::TADDR_W-1:0]] <= in_symbol;
    end
    txt_q_r <= txt_mem[i_r[bfss_pkg::TADDR_W-1:0]];
  end

  // Fill counts and drop flag; a finished search clears them.
  always_comb begin
    pat_cnt_nxt = pat_cnt_r;
    txt_cnt_nxt = txt_cnt_r;
    drop_nxt    = drop_r;
    if (pat_wr) begin
      pat_cnt_nxt = pat_cnt_r + 1'b1;
    end
    if (txt_wr) begin
      txt_cnt_nxt = txt_cnt_r + 1'b1;
    end
    if ((cmd.load_pat && !pat_room) || (cmd.load_txt && !txt_room)) begin
      drop_nxt = 1'b1;
    end
    if (cmd.finish) begin
      pat_cnt_nxt = '0;
      txt_cnt_nxt = '0;
      drop_nxt    = 1'b0;
    end
  end

  // Search indices: advance both on a match, else restart one past the last start.
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (cmd.init) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (cmd.step) begin
      if (txt_q_r == pat_q_r) begin
        i_nxt = i_r + 1'b1;
        j_nxt = j_r + 1'b1;
      end else begin
        i_nxt = start_pos + 1'b1;
        j_nxt = '0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_cnt_r <= '0;
      txt_cnt_r <= '0;
      drop_r    <= 1'b0;
    end else begin
      pat_cnt_r <= pat_cnt_nxt;
      txt_cnt_r <= txt_cnt_nxt;
      drop_r    <= drop_nxt;
    end
  end

  // Index and result registers.
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (cmd.finish) begin
      found_r <= !j_short;
      pos_r   <= j_short ? '0 : start_pos[bfss_pkg::POS_W-1:0];
      ovf_r   <= drop_r;
    end
  end

  assign out_found    = found_r;
  assign out_position = pos_r;
  assign out_overflow = ovf_r;

endmodule

// ----- rtl/brute_force_substring_search_unit.sv -----
// Top level of the brute-force substring search unit: controller and datapath.
//
//  Channel  | Ports                                        | Handshake
//  ---------+----------------------------------------------+---------------------------
//  input    | in_action, in_symbol                         | taken when start && !busy
//  result   | out_found, out_position, out_overflow        | out_valid, one cycle only
//
// A pattern or text load leaves busy low, so loads can arrive back to
// back. A search holds busy high through a check state (registered store
// read) and a compare state per byte comparison, then a final check
// state; the result strobes in the same cycle that busy is low again. Reset
// (rst_n low at a clock edge) empties both stores and clears the drop flag.
// The receiver cannot stall, so nothing waits on the output side.
module brute_force_substring_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfss_pkg::ACT_W-1:0]    in_action,
  input  logic [bfss_pkg::SYM_W-1:0]    in_symbol,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [bfss_pkg::POS_W-1:0]    out_position,
  output logic                          out_overflow
);

  bfss_pkg::ctrl_cmd_t  cmd;
  bfss_pkg::dp_status_t status;

  // Sequencing of loads and the search loop.
  bfss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Stores, indices and result registers.
  bfss_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_symbol    (in_symbol),
    .status       (status),
    .out_found    (out_found),
    .out_position (out_position),
    .out_overflow (out_overflow)
  );

endmodule
